@@ sv/csp_pkg.sv @@
// Shared widths, codes and reset values for the current source protection block.
package csp_pkg;

  localparam int unsigned ValW   = 20;
  localparam int unsigned CntW   = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [ValW-1:0]  val_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ModeW-1:0] mode_t;
  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam mode_t MODE_IDLE   = 3'd0;
  localparam mode_t MODE_NORMAL = 3'd1;
  localparam mode_t MODE_OPEN   = 3'd2;
  localparam mode_t MODE_OVER   = 3'd3;
  localparam mode_t MODE_SHORT  = 3'd4;

  localparam cmd_t CMD_TICK       = 2'd0;
  localparam cmd_t CMD_ENTER_IDLE = 2'd1;
  localparam cmd_t CMD_LEAVE_IDLE = 2'd2;

  localparam cfg_idx_t REG_OPEN_CUR  = 3'd0;
  localparam cfg_idx_t REG_OVER_CUR  = 3'd1;
  localparam cfg_idx_t REG_MIN_SET   = 3'd2;
  localparam cfg_idx_t REG_SHORT_RES = 3'd3;
  localparam cfg_idx_t REG_OPEN_CNT  = 3'd4;

  localparam val_t RST_OPEN_CUR  = 20'd100;
  localparam val_t RST_OVER_CUR  = 20'd550000;
  localparam val_t RST_MIN_SET   = 20'd1000;
  localparam val_t RST_SHORT_RES = 20'd500;
  localparam cnt_t RST_OPEN_CNT  = 8'd10;

endpackage

@@ sv/current_source_protection_fsm.sv @@
// Top level: protection state machine for a current source.
//
// Input channel (in_*): one word per tick carrying a command, the measured
// current (uA), the load resistance (mOhm) and the current setpoint (uA).
// Result channel (out_*): exactly one word per input word with the status,
// its report flag, the converter enable, fault LED, setpoint clear and beep.
// Configuration (cfg_*): write-only limits, written while the block is idle; a
// rule for the user, not enforced by the block. The result word is registered
// and valid in the cycle after input acceptance. Throughput: one word per cycle
// while no stalled result waits; the evaluation is a few compares and an 8-bit counter update.
// in_stall rises only while a result waits and out_stall is high, so the
// result register alone decides whether the next word can enter.
// A stalled result holds until taken; state advances only on acceptance.
// Reset (rst_n low, synchronous): mode idle, converter off, counter zero,
// limits back to their defaults, result register empty.
module current_source_protection_fsm
  import csp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_cmd,
  input  val_t       in_measured_current,
  input  val_t       in_load_resistance,
  input  val_t       in_current_setpoint,
  output logic       out_valid,
  input  logic       out_stall,
  output mode_t      out_status,
  output logic       out_status_valid,
  output logic       out_buck_enable,
  output logic       out_fault_led,
  output logic       out_clear_setpoint,
  output logic       out_beep,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  val_t       cfg_wdata
);

  val_t  open_cur_r, over_cur_r, min_set_r, short_res_r;
  cnt_t  open_cnt_lim_r;

  mode_t mode_r, mode_nxt;
  logic  en_r, en_nxt;
  cnt_t  cnt_r, cnt_nxt;

  logic  out_valid_r;
  mode_t status_r;
  logic  status_valid_r, buck_en_r, clear_r, beep_r;
  logic  rep_nxt, clear_nxt, beep_nxt;

  logic  in_acc;
  mode_t mode_a, mode_b;
  cnt_t  cnt_inc;
  logic  open_cond, over_cond, short_cond;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    case (in_cmd)
      CMD_ENTER_IDLE: mode_a = MODE_IDLE;
      CMD_LEAVE_IDLE: mode_a = MODE_NORMAL;
      default:        mode_a = mode_r;
    endcase
  end

  assign cnt_inc    = cnt_r + cnt_t'(1);
  assign open_cond  = en_r && (in_measured_current < open_cur_r)
                      && (in_current_setpoint >= min_set_r);
  assign over_cond  = en_r && (in_measured_current > over_cur_r);
  assign short_cond = en_r && (in_load_resistance < short_res_r);

  always_comb begin
    mode_b    = mode_a;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    rep_nxt   = 1'b0;
    clear_nxt = 1'b0;
    beep_nxt  = 1'b0;
    mode_nxt  = mode_a;
    if (mode_a == MODE_IDLE) begin
      en_nxt = 1'b0;
    end else begin
      if (open_cond) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc > open_cnt_lim_r) begin
          mode_b  = MODE_OPEN;
          cnt_nxt = '0;
        end
      end else if (over_cond) begin
        cnt_nxt = '0;
        mode_b  = MODE_OVER;
      end else if (short_cond) begin
        mode_b = MODE_SHORT;
      end else if (en_r) begin
        cnt_nxt = '0;
        mode_b  = MODE_NORMAL;
      end
      mode_nxt = mode_b;
      case (mode_b)
        MODE_OVER: begin
          en_nxt    = 1'b0;
          clear_nxt = 1'b1;
          rep_nxt   = 1'b1;
        end
        MODE_OPEN: begin
          if (in_current_setpoint < min_set_r) begin
            mode_nxt = MODE_NORMAL;
          end else begin
            rep_nxt  = 1'b1;
            beep_nxt = 1'b1;
            en_nxt   = 1'b0;
          end
        end
        MODE_SHORT, MODE_NORMAL: begin
          rep_nxt = 1'b1;
          en_nxt  = 1'b1;
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          rep_nxt  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cur_r     <= RST_OPEN_CUR;
      over_cur_r     <= RST_OVER_CUR;
      min_set_r      <= RST_MIN_SET;
      short_res_r    <= RST_SHORT_RES;
      open_cnt_lim_r <= RST_OPEN_CNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN_CUR:  open_cur_r     <= cfg_wdata;
        REG_OVER_CUR:  over_cur_r     <= cfg_wdata;
        REG_MIN_SET:   min_set_r      <= cfg_wdata;
        REG_SHORT_RES: short_res_r    <= cfg_wdata;
        REG_OPEN_CNT:  open_cnt_lim_r <= cfg_wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      en_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        en_r   <= en_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r       <= mode_nxt;
      status_valid_r <= rep_nxt;
      buck_en_r      <= en_nxt;
      clear_r        <= clear_nxt;
      beep_r         <= beep_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_status_valid   = status_valid_r;
  assign out_buck_enable    = buck_en_r;
  assign out_fault_led      = ~buck_en_r;
  assign out_clear_setpoint = clear_r;
  assign out_beep           = beep_r;

  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> !en_r)
    else $error("converter enabled while idle");

  a_beep_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beep) |-> (!out_buck_enable && out_status == MODE_OPEN))
    else $error("beep without open-load shutdown");

  a_clear_over: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clear_setpoint) |-> (out_status == MODE_OVER && !out_buck_enable))
    else $error("setpoint clear without overcurrent");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status_valid)
      |-> (out_status == MODE_IDLE || out_status == MODE_NORMAL))
    else $error("unreported status is neither idle nor normal");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid && out_status == mode_r))
    else $error("result does not follow accepted word");

endmodule
